### rtl/chpp_pkg.sv
// Shared types, codes and property tables for the content-header property parser.
package chpp_pkg;

    localparam logic [3:0]  PROP_COUNT    = 4'd14;
    localparam int          FLAG_MSB      = 15;
    localparam logic [3:0]  DELIVERY_PROP = 4'd3;
    localparam logic [7:0]  PERSIST_MODE  = 8'd2;
    localparam logic [3:0]  CLASS_END     = 4'd2;
    localparam logic [3:0]  WEIGHT_END    = 4'd4;
    localparam logic [3:0]  HDR_LEN       = 4'd12;
    localparam logic [3:0]  FLAGS_END     = 4'd14;
    localparam logic [3:0]  TLEN_BYTES    = 4'd4;
    localparam logic [31:0] TS_TAIL       = 32'd7;
    localparam logic [15:0] EXPECTED_CLASS_RESET = 16'd60;

    // status codes; property kinds are coded as their truncation status
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_SHORT_HDR   = 3'd1;
    localparam logic [2:0] ST_BAD_CLASS   = 3'd2;
    localparam logic [2:0] ST_SHORT_FLAGS = 3'd3;
    localparam logic [2:0] ST_BAD_STRING  = 3'd4;
    localparam logic [2:0] ST_SHORT_OCTET = 3'd5;
    localparam logic [2:0] ST_SHORT_TS    = 3'd6;
    localparam logic [2:0] ST_SHORT_TABLE = 3'd7;

    typedef enum logic [2:0] {
        PH_HEAD,
        PH_START,
        PH_SKIP,
        PH_TLEN,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [3:0]  hdr_cnt;
        logic [15:0] hdr_class;
        logic [15:0] weight;
        logic [63:0] size;
        logic [15:0] flags;
        logic [3:0]  prop_idx;
        phase_t      phase;
        logic [31:0] skip_cnt;
        logic        persist;
        logic [2:0]  err;
    } parse_state_t;

    localparam parse_state_t PARSE_CLEAR = '{
        hdr_cnt:   4'd0,
        hdr_class: 16'd0,
        weight:    16'd0,
        size:      64'd0,
        flags:     16'd0,
        prop_idx:  4'd0,
        phase:     PH_HEAD,
        skip_cnt:  32'd0,
        persist:   1'b0,
        err:       ST_OK
    };

    function automatic logic [2:0] prop_kind(input logic [3:0] idx);
        logic [2:0] kind;
        case (idx)
            4'd0:    kind = ST_BAD_STRING;
            4'd1:    kind = ST_BAD_STRING;
            4'd2:    kind = ST_SHORT_TABLE;
            4'd3:    kind = ST_SHORT_OCTET;
            4'd4:    kind = ST_SHORT_OCTET;
            4'd5:    kind = ST_BAD_STRING;
            4'd6:    kind = ST_BAD_STRING;
            4'd7:    kind = ST_BAD_STRING;
            4'd8:    kind = ST_BAD_STRING;
            4'd9:    kind = ST_SHORT_TS;
            4'd10:   kind = ST_BAD_STRING;
            4'd11:   kind = ST_BAD_STRING;
            4'd12:   kind = ST_BAD_STRING;
            4'd13:   kind = ST_BAD_STRING;
            default: kind = ST_OK;
        endcase
        return kind;
    endfunction

    // first flagged property at or after idx, PROP_COUNT if none
    function automatic logic [3:0] next_selected(input logic [15:0] flags,
                                                 input logic [3:0] idx);
        logic [3:0] sel;
        sel = PROP_COUNT;
        for (int i = int'(PROP_COUNT) - 1; i >= 0; i--) begin
            if (4'(i) >= idx && flags[FLAG_MSB - i]) begin
                sel = 4'(i);
            end
        end
        return sel;
    endfunction

endpackage

### rtl/chpp_result.sv
// Result word builder: status, header fields and persistence from the updated parse state.
module chpp_result (
    input  chpp_pkg::parse_state_t st,
    output logic [2:0]             status,
    output logic [15:0]            hdr_class,
    output logic [63:0]            content_size,
    output logic                   persistent
);

    logic [3:0] sel;
    logic       head_done;

    assign sel = chpp_pkg::next_selected(st.flags, st.prop_idx);

    always_comb begin
        status = chpp_pkg::ST_OK;
        if (st.err != chpp_pkg::ST_OK) begin
            status = st.err;
        end else begin
            case (st.phase)
                chpp_pkg::PH_HEAD: begin
                    status = (st.hdr_cnt < chpp_pkg::HDR_LEN) ? chpp_pkg::ST_SHORT_HDR
                                                              : chpp_pkg::ST_SHORT_FLAGS;
                end
                chpp_pkg::PH_START: begin
                    status = chpp_pkg::prop_kind(sel);
                end
                chpp_pkg::PH_SKIP, chpp_pkg::PH_TLEN: begin
                    status = chpp_pkg::prop_kind(st.prop_idx);
                end
                default: begin
                    status = chpp_pkg::ST_OK;
                end
            endcase
        end
    end

    assign head_done    = (st.phase != chpp_pkg::PH_HEAD) || (st.hdr_cnt >= chpp_pkg::HDR_LEN);
    assign hdr_class    = head_done ? st.hdr_class : 16'd0;
    assign content_size = head_done ? st.size : 64'd0;
    assign persistent   = (status == chpp_pkg::ST_OK) && st.persist;

endmodule

### rtl/content_header_property_parser.sv
// Top level of the content-header property parser: byte intake, parse state and result register.
//
// Takes one header byte per cycle and gives one result word on the cycle after the
// byte marked last is accepted. Each byte updates the parse state (header shift
// registers, property index, skip counter) as it is accepted, so the sustained rate
// is one byte per clock; s_ready drops only while a result waits in the output
// register and m_ready is low. Status codes: 0 ok, 1 short header, 2 bad class,
// 3 short flags, 4 bad string, 5 short octet, 6 short timestamp, 7 short table.
// m_hdr_class and m_content_size read zero unless all 12 header bytes arrived; persistent is set
// only for a successful parse whose delivery mode byte is 2. The user must write the expected
// class id register (reset 60) via the cfg channel while idle; the block does not enforce it.
module content_header_property_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [15:0] m_hdr_class,
    output logic [63:0] m_content_size,
    output logic        m_persistent
);

    logic [15:0]            expected_class_reg;
    chpp_pkg::parse_state_t state_reg;
    chpp_pkg::parse_state_t state_next;
    logic [3:0]             sel;
    logic                   accept;
    logic                   out_valid_reg;
    logic [2:0]             status_reg;
    logic [15:0]            hdr_class_reg;
    logic [63:0]            content_size_reg;
    logic                   persistent_reg;
    logic [2:0]             res_status;
    logic [15:0]            res_hdr_class;
    logic [63:0]            res_content_size;
    logic                   res_persistent;

    assign cfg_ready = 1'b1;
    assign s_ready   = !out_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign sel       = chpp_pkg::next_selected(state_reg.flags, state_reg.prop_idx);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_class_reg <= chpp_pkg::EXPECTED_CLASS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            expected_class_reg <= cfg_data;
        end
    end

    // parse state next value for one byte
    always_comb begin
        state_next = state_reg;
        if (state_reg.err == chpp_pkg::ST_OK) begin
            case (state_reg.phase)
                chpp_pkg::PH_HEAD: begin
                    if (state_reg.hdr_cnt < chpp_pkg::CLASS_END) begin
                        state_next.hdr_class = {state_reg.hdr_class[7:0], s_data_byte};
                    end else if (state_reg.hdr_cnt < chpp_pkg::WEIGHT_END) begin
                        state_next.weight = {state_reg.weight[7:0], s_data_byte};
                    end else if (state_reg.hdr_cnt < chpp_pkg::HDR_LEN) begin
                        state_next.size = {state_reg.size[55:0], s_data_byte};
                    end else begin
                        state_next.flags = {state_reg.flags[7:0], s_data_byte};
                    end
                    state_next.hdr_cnt = state_reg.hdr_cnt + 4'd1;
                    if (state_next.hdr_cnt == chpp_pkg::HDR_LEN &&
                        (state_reg.hdr_class != expected_class_reg ||
                         state_reg.weight != 16'd0)) begin
                        state_next.err = chpp_pkg::ST_BAD_CLASS;
                    end else if (state_next.hdr_cnt == chpp_pkg::FLAGS_END) begin
                        state_next.phase    = chpp_pkg::PH_START;
                        state_next.prop_idx = 4'd0;
                    end
                end
                chpp_pkg::PH_START: begin
                    if (sel == chpp_pkg::PROP_COUNT) begin
                        state_next.phase    = chpp_pkg::PH_DONE;
                        state_next.prop_idx = chpp_pkg::PROP_COUNT;
                    end else begin
                        state_next.prop_idx = sel;
                        case (chpp_pkg::prop_kind(sel))
                            chpp_pkg::ST_BAD_STRING: begin
                                if (s_data_byte == 8'd0) begin
                                    state_next.prop_idx = sel + 4'd1;
                                end else begin
                                    state_next.skip_cnt = {24'd0, s_data_byte};
                                    state_next.phase    = chpp_pkg::PH_SKIP;
                                end
                            end
                            chpp_pkg::ST_SHORT_OCTET: begin
                                if (sel == chpp_pkg::DELIVERY_PROP) begin
                                    state_next.persist = (s_data_byte == chpp_pkg::PERSIST_MODE);
                                end
                                state_next.prop_idx = sel + 4'd1;
                            end
                            chpp_pkg::ST_SHORT_TS: begin
                                state_next.skip_cnt = chpp_pkg::TS_TAIL;
                                state_next.phase    = chpp_pkg::PH_SKIP;
                            end
                            default: begin
                                state_next.skip_cnt = {24'd0, s_data_byte};
                                state_next.hdr_cnt  = 4'd1;
                                state_next.phase    = chpp_pkg::PH_TLEN;
                            end
                        endcase
                    end
                end
                chpp_pkg::PH_SKIP: begin
                    state_next.skip_cnt = state_reg.skip_cnt - 32'd1;
                    if (state_next.skip_cnt == 32'd0) begin
                        state_next.prop_idx = state_reg.prop_idx + 4'd1;
                        state_next.phase    = chpp_pkg::PH_START;
                    end
                end
                chpp_pkg::PH_TLEN: begin
                    state_next.skip_cnt = {state_reg.skip_cnt[23:0], s_data_byte};
                    state_next.hdr_cnt  = state_reg.hdr_cnt + 4'd1;
                    if (state_next.hdr_cnt >= chpp_pkg::TLEN_BYTES) begin
                        if (state_next.skip_cnt == 32'd0) begin
                            state_next.prop_idx = state_reg.prop_idx + 4'd1;
                            state_next.phase    = chpp_pkg::PH_START;
                        end else begin
                            state_next.phase = chpp_pkg::PH_SKIP;
                        end
                    end
                end
                default: begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    chpp_result u_result (
        .st           (state_next),
        .status       (res_status),
        .hdr_class    (res_hdr_class),
        .content_size (res_content_size),
        .persistent   (res_persistent)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= chpp_pkg::PARSE_CLEAR;
        end else if (accept) begin
            state_reg <= s_last_byte ? chpp_pkg::PARSE_CLEAR : state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept && s_last_byte) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_last_byte) begin
            status_reg       <= res_status;
            hdr_class_reg    <= res_hdr_class;
            content_size_reg <= res_content_size;
            persistent_reg   <= res_persistent;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_status       = status_reg;
    assign m_hdr_class    = hdr_class_reg;
    assign m_content_size = content_size_reg;
    assign m_persistent   = persistent_reg;

    a_prop_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.prop_idx <= chpp_pkg::PROP_COUNT)
        else $error("property index past last property");

    a_hdr_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.hdr_cnt <= chpp_pkg::FLAGS_END)
        else $error("header count out of range");

    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last_byte) |=> m_valid)
        else $error("last word accepted without result");

    a_persist_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_persistent) |-> (m_status == chpp_pkg::ST_OK))
        else $error("persistent reported on failed parse");

endmodule

### verif/testbench.sv
// Self-checking testbench for the content-header property parser: directed table plus random payloads.
module testbench;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 6;
    localparam int ITEM_TARGET  = 450;
    localparam int STALL_LIMIT  = 5000;
    localparam int IDLE_SETTLE  = 4;
    localparam int END_SETTLE   = 8;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] hdr_class;
        logic [63:0] content_size;
        logic        persistent;
    } hdr_result_t;

    typedef struct packed {
        logic [15:0]  cls;
        logic [15:0]  wgt;
        logic [63:0]  size;
        logic [15:0]  flags;
        logic [191:0] tail;
        int           tail_len;
        int           cut;
        bit           known;
        hdr_result_t  want;
    } dir_row_t;

    localparam hdr_result_t NONE_KNOWN = '0;
    localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;

    // truncation code of each property doubles as its kind
    localparam logic [2:0] KIND_OF [14] = '{
        chpp_pkg::ST_BAD_STRING, chpp_pkg::ST_BAD_STRING, chpp_pkg::ST_SHORT_TABLE,
        chpp_pkg::ST_SHORT_OCTET, chpp_pkg::ST_SHORT_OCTET, chpp_pkg::ST_BAD_STRING,
        chpp_pkg::ST_BAD_STRING, chpp_pkg::ST_BAD_STRING, chpp_pkg::ST_BAD_STRING,
        chpp_pkg::ST_SHORT_TS, chpp_pkg::ST_BAD_STRING, chpp_pkg::ST_BAD_STRING,
        chpp_pkg::ST_BAD_STRING, chpp_pkg::ST_BAD_STRING
    };

    localparam dir_row_t DIR_ROWS [18] = '{
        '{16'hFF3C, 16'h0000, 64'd0, 16'h0000, 192'd0, 0, 1, 1'b1,
          '{chpp_pkg::ST_SHORT_HDR, 16'd0, 64'd0, 1'b0}},
        '{16'hFFFF, 16'h0000, 64'h0123_4567_89AB_CDEF, 16'h0000, 192'd0, 0, 12, 1'b1,
          '{chpp_pkg::ST_BAD_CLASS, 16'hFFFF, 64'h0123_4567_89AB_CDEF, 1'b0}},
        '{16'd60, 16'h8000, 64'd0, 16'hFFFF, 192'hFFFF, 2, 0, 1'b1,
          '{chpp_pkg::ST_BAD_CLASS, 16'd60, 64'd0, 1'b0}},
        '{16'd60, 16'h0000, ALL_ONES, 16'h0000, 192'd0, 0, 13, 1'b1,
          '{chpp_pkg::ST_SHORT_FLAGS, 16'd60, ALL_ONES, 1'b0}},
        '{16'd60, 16'h0000, ALL_ONES, 16'h0000, 192'd0, 0, 0, 1'b1,
          '{chpp_pkg::ST_OK, 16'd60, ALL_ONES, 1'b0}},
        '{16'd60, 16'h0000, 64'd0, 16'h0003, 192'd0, 0, 0, 1'b1,
          '{chpp_pkg::ST_OK, 16'd60, 64'd0, 1'b0}},
        '{16'd60, 16'h0000, 64'hFEDC_BA98_7654_3210, 16'h1000, 192'h02, 1, 0, 1'b1,
          '{chpp_pkg::ST_OK, 16'd60, 64'hFEDC_BA98_7654_3210, 1'b1}},
        '{16'd60, 16'h0000, 64'h10, 16'h1000, 192'd0, 0, 0, 1'b1,
          '{chpp_pkg::ST_SHORT_OCTET, 16'd60, 64'h10, 1'b0}},
        '{16'd60, 16'h0000, 64'h20, 16'h8000, 192'h00, 1, 0, 1'b0, NONE_KNOWN},
        '{16'd60, 16'h0000, 64'h21, 16'h8000, 192'h03_4142, 3, 0, 1'b0, NONE_KNOWN},
        '{16'd60, 16'h0000, 64'h30, 16'h2000, 192'h0, 4, 0, 1'b0, NONE_KNOWN},
        '{16'd60, 16'h0000, 64'h31, 16'h2000, 192'h0000_0002_AABB, 6, 17, 1'b0, NONE_KNOWN},
        '{16'd60, 16'h0000, 64'h40, 16'h0040, 192'h1122_3344_5566_7788, 8, 0, 1'b0,
          NONE_KNOWN},
        '{16'd60, 16'h0000, 64'h41, 16'h0040, 192'h1122_3344_5566_7788, 8, 19, 1'b0,
          NONE_KNOWN},
        '{16'd60, 16'h0000, 64'h50, 16'hFFFC,
          192'h0000_0000_0000_0207_0000_0000_1122_3344_5566_7788_0000_0000, 24, 0, 1'b0,
          NONE_KNOWN},
        '{16'd60, 16'h0000, 64'h60, 16'h1000, 192'h02_FFFF, 3, 0, 1'b0, NONE_KNOWN},
        '{16'd60, 16'h0000, 64'h70, 16'h1800, 192'h02, 1, 0, 1'b0, NONE_KNOWN},
        '{16'd60, 16'h0000, 64'h80, 16'h1000, 192'h03, 1, 0, 1'b0, NONE_KNOWN}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [15:0] m_hdr_class;
    logic [63:0] m_content_size;
    logic        m_persistent;

    int src_idle = 0;
    int sink_stall = 0;
    int error_count = 0;
    int idle_cycles = 0;

    hdr_result_t header_results_q[$];
    logic [7:0]  payload_q[$];

    // predicted parser state
    logic [15:0]       want_class = chpp_pkg::EXPECTED_CLASS_RESET;
    logic [3:0]        p_hdr_cnt;
    logic [15:0]       p_class;
    logic [15:0]       p_weight;
    logic [63:0]       p_size;
    logic [15:0]       p_flags;
    logic [3:0]        p_idx;
    chpp_pkg::phase_t  p_phase;
    logic [31:0]       p_skip;
    logic              p_persist;
    logic [2:0]        p_err;

    content_header_property_parser i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_hdr_class   (m_hdr_class),
        .m_content_size(m_content_size),
        .m_persistent  (m_persistent)
    );

    always #HALF_PERIOD aclk = ~aclk;

    function automatic void reset_parse();
        p_hdr_cnt = '0;
        p_class   = '0;
        p_weight  = '0;
        p_size    = '0;
        p_flags   = '0;
        p_idx     = '0;
        p_phase   = chpp_pkg::PH_HEAD;
        p_skip    = '0;
        p_persist = 1'b0;
        p_err     = chpp_pkg::ST_OK;
    endfunction

    function automatic logic [3:0] first_flagged();
        for (int i = 0; i < int'(chpp_pkg::PROP_COUNT); i++) begin
            if (4'(i) >= p_idx && p_flags[chpp_pkg::FLAG_MSB - i]) begin
                return 4'(i);
            end
        end
        return chpp_pkg::PROP_COUNT;
    endfunction

    function automatic void close_prop();
        p_idx   = p_idx + 4'd1;
        p_phase = chpp_pkg::PH_START;
    endfunction

    // advance the parse by one byte; on the last byte produce the result word
    function automatic void parse_byte(input logic [7:0] b, input logic last,
                                       output bit done, output hdr_result_t res);
        logic [3:0] sel;
        logic [2:0] st;
        bit         head_done;
        done = 1'b0;
        res  = '0;
        if (p_err == chpp_pkg::ST_OK) begin
            case (p_phase)
                chpp_pkg::PH_HEAD: begin
                    if (p_hdr_cnt < chpp_pkg::CLASS_END) p_class = {p_class[7:0], b};
                    else if (p_hdr_cnt < chpp_pkg::WEIGHT_END) p_weight = {p_weight[7:0], b};
                    else if (p_hdr_cnt < chpp_pkg::HDR_LEN) p_size = {p_size[55:0], b};
                    else p_flags = {p_flags[7:0], b};
                    p_hdr_cnt = p_hdr_cnt + 4'd1;
                    if (p_hdr_cnt == chpp_pkg::HDR_LEN &&
                        (p_class != want_class || p_weight != 16'd0)) begin
                        p_err = chpp_pkg::ST_BAD_CLASS;
                    end else if (p_hdr_cnt == chpp_pkg::FLAGS_END) begin
                        p_phase = chpp_pkg::PH_START;
                        p_idx   = '0;
                    end
                end
                chpp_pkg::PH_START: begin
                    sel = first_flagged();
                    if (sel >= chpp_pkg::PROP_COUNT) begin
                        p_phase = chpp_pkg::PH_DONE;
                        p_idx   = chpp_pkg::PROP_COUNT;
                    end else begin
                        p_idx = sel;
                        case (KIND_OF[sel])
                            chpp_pkg::ST_BAD_STRING: begin
                                if (b == 8'd0) begin
                                    close_prop();
                                end else begin
                                    p_skip  = 32'(b);
                                    p_phase = chpp_pkg::PH_SKIP;
                                end
                            end
                            chpp_pkg::ST_SHORT_OCTET: begin
                                if (sel == chpp_pkg::DELIVERY_PROP)
                                    p_persist = (b == chpp_pkg::PERSIST_MODE);
                                close_prop();
                            end
                            chpp_pkg::ST_SHORT_TS: begin
                                p_skip  = chpp_pkg::TS_TAIL;
                                p_phase = chpp_pkg::PH_SKIP;
                            end
                            default: begin
                                p_skip    = 32'(b);
                                p_hdr_cnt = 4'd1;
                                p_phase   = chpp_pkg::PH_TLEN;
                            end
                        endcase
                    end
                end
                chpp_pkg::PH_SKIP: begin
                    p_skip = p_skip - 32'd1;
                    if (p_skip == 32'd0) close_prop();
                end
                chpp_pkg::PH_TLEN: begin
                    p_skip    = {p_skip[23:0], b};
                    p_hdr_cnt = p_hdr_cnt + 4'd1;
                    if (p_hdr_cnt >= chpp_pkg::TLEN_BYTES) begin
                        if (p_skip == 32'd0) close_prop();
                        else p_phase = chpp_pkg::PH_SKIP;
                    end
                end
                default: ;
            endcase
        end
        if (last) begin
            if (p_err != chpp_pkg::ST_OK) begin
                st = p_err;
            end else begin
                case (p_phase)
                    chpp_pkg::PH_HEAD: st = (p_hdr_cnt < chpp_pkg::HDR_LEN)
                                            ? chpp_pkg::ST_SHORT_HDR
                                            : chpp_pkg::ST_SHORT_FLAGS;
                    chpp_pkg::PH_START: begin
                        sel = first_flagged();
                        st  = (sel < chpp_pkg::PROP_COUNT) ? KIND_OF[sel] : chpp_pkg::ST_OK;
                    end
                    chpp_pkg::PH_SKIP, chpp_pkg::PH_TLEN:
                        st = (p_idx < chpp_pkg::PROP_COUNT) ? KIND_OF[p_idx] : chpp_pkg::ST_OK;
                    default: st = chpp_pkg::ST_OK;
                endcase
            end
            head_done        = (p_phase != chpp_pkg::PH_HEAD) || (p_hdr_cnt >= chpp_pkg::HDR_LEN);
            res.status       = st;
            res.hdr_class    = head_done ? p_class : 16'd0;
            res.content_size = head_done ? p_size : 64'd0;
            res.persistent   = (st == chpp_pkg::ST_OK) && p_persist;
            done             = 1'b1;
            reset_parse();
        end
    endfunction

    function automatic void put_header(input logic [15:0] cls, input logic [15:0] wgt,
                                       input logic [63:0] size, input logic [15:0] flags);
        payload_q.push_back(cls[15:8]);
        payload_q.push_back(cls[7:0]);
        payload_q.push_back(wgt[15:8]);
        payload_q.push_back(wgt[7:0]);
        for (int k = 7; k >= 0; k--) payload_q.push_back(size[8*k +: 8]);
        payload_q.push_back(flags[15:8]);
        payload_q.push_back(flags[7:0]);
    endfunction

    function automatic void build_random_payload();
        logic [15:0] flags;
        logic [63:0] size;
        logic [31:0] tlen;
        int          len;
        int          keep;
        int          pick;
        bit          stop;
        payload_q.delete();
        if ($urandom_range(9) == 0) begin
            len = $urandom_range(1, 20);
            repeat (len) payload_q.push_back(8'($urandom));
            return;
        end
        flags = 16'($urandom);
        if ($urandom_range(1) == 1) flags = flags & 16'($urandom);
        case ($urandom_range(9))
            0:       size = 64'd0;
            1:       size = ALL_ONES;
            default: size = {$urandom, $urandom};
        endcase
        put_header(($urandom_range(9) == 0) ? 16'($urandom) : want_class,
                   ($urandom_range(9) == 0) ? 16'($urandom) : 16'd0, size, flags);
        stop = 1'b0;
        for (int i = 0; i < int'(chpp_pkg::PROP_COUNT) && !stop; i++) begin
            if (flags[chpp_pkg::FLAG_MSB - i]) begin
                case (KIND_OF[i])
                    chpp_pkg::ST_BAD_STRING: begin
                        len = ($urandom_range(29) == 0) ? $urandom_range(7, 255)
                                                        : $urandom_range(0, 6);
                        payload_q.push_back(8'(len));
                        repeat (len) payload_q.push_back(8'($urandom));
                    end
                    chpp_pkg::ST_SHORT_OCTET: begin
                        if (4'(i) == chpp_pkg::DELIVERY_PROP && $urandom_range(1) == 1)
                            payload_q.push_back(chpp_pkg::PERSIST_MODE);
                        else
                            payload_q.push_back(8'($urandom));
                    end
                    chpp_pkg::ST_SHORT_TS: repeat (8) payload_q.push_back(8'($urandom));
                    default: begin
                        pick = $urandom_range(19);
                        if (pick == 0) tlen = $urandom;
                        else if (pick == 1) tlen = $urandom_range(7, 40);
                        else tlen = $urandom_range(0, 6);
                        for (int k = 3; k >= 0; k--) payload_q.push_back(tlen[8*k +: 8]);
                        if (tlen > 32'd64) begin
                            // oversized table: cut the payload short inside it
                            repeat ($urandom_range(0, 5)) payload_q.push_back(8'($urandom));
                            stop = 1'b1;
                        end else begin
                            repeat (tlen) payload_q.push_back(8'($urandom));
                        end
                    end
                endcase
            end
        end
        if (!stop && $urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) payload_q.push_back(8'($urandom));
        if ($urandom_range(4) == 0) begin
            keep = $urandom_range(1, payload_q.size());
            while (payload_q.size() > keep) void'(payload_q.pop_back());
        end
    endfunction

    // entered and left at a falling edge
    task automatic push_byte(input logic [7:0] b, input logic last, input bit known,
                             input hdr_result_t typed);
        bit          done;
        hdr_result_t res;
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        parse_byte(b, last, done, res);
        if (done) header_results_q.push_back(known ? typed : res);
        @(negedge aclk);
    endtask

    task automatic send_payload(input bit known, input hdr_result_t typed);
        int n;
        n = payload_q.size();
        for (int k = 0; k < n; k++) push_byte(payload_q[k], k == n - 1, known, typed);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (header_results_q.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_class_cfg(input logic [15:0] value);
        drain_results();
        repeat (IDLE_SETTLE) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        want_class = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall);
    end

    always @(posedge aclk) begin : check_results
        hdr_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (header_results_q.size() == 0) begin
                $error("result word with nothing expected");
                error_count++;
            end else begin
                want = header_results_q.pop_front();
                if (m_status !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d", want.status, m_status);
                    error_count++;
                end
                if (m_hdr_class !== want.hdr_class) begin
                    $error("hdr_class mismatch: expected %h, actual %h",
                           want.hdr_class, m_hdr_class);
                    error_count++;
                end
                if (m_content_size !== want.content_size) begin
                    $error("content_size mismatch: expected %h, actual %h",
                           want.content_size, m_content_size);
                    error_count++;
                end
                if (m_persistent !== want.persistent) begin
                    $error("persistent mismatch: expected %0d, actual %0d",
                           want.persistent, m_persistent);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin : stimulus
        dir_row_t    row;
        logic [15:0] cls_setting;
        int          sent_bytes;
        int          quota;
        int          phase_bytes;
        reset_parse();
        sent_bytes = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (DIR_ROWS[n]) begin
            row = DIR_ROWS[n];
            payload_q.delete();
            put_header(row.cls, row.wgt, row.size, row.flags);
            for (int k = 0; k < row.tail_len; k++)
                payload_q.push_back(row.tail[8*(row.tail_len - 1 - k) +: 8]);
            if (row.cut != 0)
                while (payload_q.size() > row.cut) void'(payload_q.pop_back());
            send_payload(row.known, row.want);
            sent_bytes += payload_q.size();
        end

        // remaining bytes split evenly over the idling phases
        quota = (ITEM_TARGET - sent_bytes) / 4;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle = 0;  sink_stall = 0;  cls_setting = 16'hFFFF; end
                1: begin src_idle = 81; sink_stall = 0;  cls_setting = 16'h0000; end
                2: begin src_idle = 0;  sink_stall = 81; cls_setting = 16'($urandom); end
                default: begin
                    src_idle = 27; sink_stall = 27;
                    cls_setting = chpp_pkg::EXPECTED_CLASS_RESET;
                end
            endcase
            write_class_cfg(cls_setting);
            phase_bytes = 0;
            while (phase_bytes < quota) begin
                if ($urandom_range(7) == 0) drain_results();
                build_random_payload();
                send_payload(1'b0, NONE_KNOWN);
                phase_bytes += payload_q.size();
            end
        end

        drain_results();
        repeat (END_SETTLE) @(posedge aclk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
